@@ src/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CFG_W  = CNT_W;

    // remainder unit: bits retired per cycle
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = (KEY_BITS + MOD_DIGIT - 1) / MOD_DIGIT;
    localparam int MOD_PAD_W = MOD_STEPS * MOD_DIGIT;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // operation codes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_NEXT   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZEROKEY  = 2'd3;

    // configuration register indexes
    localparam logic CFG_SLOTS = 1'b0;
    localparam logic CFG_DUP   = 1'b1;

    typedef struct packed {
        logic [2:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_W-1:0]     start_slot;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_BITS-1:0] found_value;
        logic [CNT_W-1:0]      used_count;
    } t_rsp;

    // next slot with wrap at the slot count in use
    function automatic logic [SLOT_W-1:0] adv_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, s} + CNT_W'(1);
        return (inc >= n) ? '0 : inc[SLOT_W-1:0];
    endfunction

endpackage

@@ src/lpht_mod_unit.sv @@
// ----------------------------------------------------------------------------
// lpht_mod_unit
// Iterative key remainder: MOD_DIGIT bits of the key per cycle.
// ----------------------------------------------------------------------------
module lpht_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_BITS-1:0] i_dividend,
    input  logic [lpht_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [lpht_pkg::SLOT_W-1:0]   o_rem
);

    logic                             r_busy;
    logic                             r_done;
    logic [lpht_pkg::MOD_CNT_W-1:0]   r_cnt;
    logic [lpht_pkg::MOD_PAD_W-1:0]   r_sh;
    logic [lpht_pkg::CNT_W-1:0]       r_rem;
    logic [lpht_pkg::CNT_W-1:0]       r_div;
    logic [lpht_pkg::CNT_W-1:0]       n_rem;

    // restoring remainder, MOD_DIGIT steps on narrow values
    always_comb begin
        logic [lpht_pkg::CNT_W:0]   t;
        logic [lpht_pkg::CNT_W-1:0] rem;
        rem = r_rem;
        for (int d = 0; d < lpht_pkg::MOD_DIGIT; d++) begin
            t = {rem, r_sh[lpht_pkg::MOD_PAD_W-1-d]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem = t[lpht_pkg::CNT_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + lpht_pkg::MOD_CNT_W'(1);
                if (r_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= lpht_pkg::MOD_PAD_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= r_sh << lpht_pkg::MOD_DIGIT;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[lpht_pkg::SLOT_W-1:0];

endmodule

@@ src/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key/value table, open addressing with linear probing, in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_req_valid/o_req_ready (t_req: op, key, value,
//   start_slot); one response leaves per request on o_rsp_valid/i_rsp_ready
//   (t_rsp: status, slot, found_value, used_count). Configuration is a plain
//   write port (i_cfg_we, i_cfg_idx, i_cfg_data), written while idle.
//   One request is worked at a time. Lookup, insert and remove first take the
//   home slot from a remainder unit, then probe the key memory, one read and
//   one compare per slot; next duplicate skips the remainder step. Remove
//   adds, for every following entry of the cluster, a scan read and check
//   plus a full reinsert (remainder and probes). Clear sweeps all 1024 slots,
//   one a cycle. After reset the key memory is cleared by the same sweep;
//   o_req_ready stays low until it ends, config writes are taken as usual.
//   A finished response sits in the output register; while the receiver
//   stalls, the next request may still be accepted and worked, and its
//   result waits until the output register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  lpht_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output lpht_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lpht_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int SW = lpht_pkg::SLOT_W;
    localparam int CW = lpht_pkg::CNT_W;
    localparam int KW = lpht_pkg::KEY_BITS;
    localparam int VW = lpht_pkg::VALUE_BITS;

    typedef enum logic [7:0] {
        S_CLR      = 8'b0000_0001,  // sweep key memory to empty
        S_IDLE     = 8'b0000_0010,
        S_MOD      = 8'b0000_0100,  // home slot in progress
        S_PRB      = 8'b0000_1000,  // read issued at r_s
        S_CHK      = 8'b0001_0000,  // compare read data
        S_SCAN_RD  = 8'b0010_0000,  // remove: read next cluster entry
        S_SCAN_CHK = 8'b0100_0000,
        S_DONE     = 8'b1000_0000   // result waits for output register
    } t_state;

    typedef enum logic [1:0] {
        M_FIND = 2'b00,  // lookup and remove
        M_PUT  = 2'b01,  // insert and reinsert
        M_NEXT = 2'b10   // next duplicate
    } t_mode;

    // memories
    logic [KW-1:0] key_mem [lpht_pkg::MAX_SLOTS];
    logic [VW-1:0] val_mem [lpht_pkg::MAX_SLOTS];
    logic [KW-1:0] r_key_rd;
    logic [VW-1:0] r_val_rd;

    // control registers
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [SW-1:0]  r_sweep, n_sweep;
    logic           r_clr_rsp, n_clr_rsp;
    logic [CW-1:0]  r_slots;
    logic           r_dup;
    logic           r_rsp_valid;

    // work registers
    logic [2:0]     r_op, n_op;
    logic [KW-1:0]  r_key, n_key;
    logic [VW-1:0]  r_val, n_val;
    t_mode          r_mode, n_mode;
    logic           r_reins, n_reins;
    logic [SW-1:0]  r_s, n_s;
    logic [CW-1:0]  r_i, n_i;
    logic [SW-1:0]  r_scan, n_scan;
    logic [CW-1:0]  r_j, n_j;
    logic [KW-1:0]  r_mk, n_mk;
    logic [VW-1:0]  r_mv, n_mv;
    logic [1:0]     r_status, n_status;
    logic [SW-1:0]  r_slot, n_slot;
    logic [VW-1:0]  r_fv, n_fv;
    lpht_pkg::t_rsp r_rsp;

    // combinational controls
    logic [CW-1:0]  n_active;
    logic [SW-1:0]  raddr;
    logic           key_we, val_we;
    logic [SW-1:0]  key_waddr, val_waddr;
    logic [KW-1:0]  key_wdata;
    logic [VW-1:0]  val_wdata;
    logic           mod_start;
    logic [KW-1:0]  mod_key;
    logic           mod_done;
    logic [SW-1:0]  mod_rem;
    logic           rsp_load;
    logic           req_acc;

    // probe comparisons
    logic [KW-1:0]  k_cur;
    logic [VW-1:0]  v_cur;
    logic           is_empty, is_match, exhausted;

    // effective slot count: 0 acts as 1, above the table acts as the table
    always_comb begin
        if (r_slots == '0) begin
            n_active = CW'(1);
        end else if (r_slots > CW'(lpht_pkg::MAX_SLOTS)) begin
            n_active = CW'(lpht_pkg::MAX_SLOTS);
        end else begin
            n_active = r_slots;
        end
    end

    lpht_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_key),
        .i_divisor  (n_active),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign req_acc   = i_req_valid && o_req_ready;
    assign rsp_load  = (r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready);
    assign raddr     = (r_state == S_SCAN_RD) ? r_scan : r_s;
    assign k_cur     = r_reins ? r_mk : r_key;
    assign v_cur     = r_reins ? r_mv : r_val;
    assign is_empty  = (r_key_rd == '0);
    assign is_match  = (r_key_rd == k_cur);
    assign exhausted = ((r_i + CW'(1)) >= n_active);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sweep   = r_sweep;
        n_clr_rsp = r_clr_rsp;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_mode    = r_mode;
        n_reins   = r_reins;
        n_s       = r_s;
        n_i       = r_i;
        n_scan    = r_scan;
        n_j       = r_j;
        n_mk      = r_mk;
        n_mv      = r_mv;
        n_status  = r_status;
        n_slot    = r_slot;
        n_fv      = r_fv;
        key_we    = 1'b0;
        key_waddr = r_s;
        key_wdata = '0;
        val_we    = 1'b0;
        val_waddr = r_s;
        val_wdata = v_cur;
        mod_start = 1'b0;
        mod_key   = r_key_rd;

        case (r_state)
            S_CLR: begin
                key_we    = 1'b1;
                key_waddr = r_sweep;
                n_sweep   = r_sweep + SW'(1);
                if (r_sweep == SW'(lpht_pkg::MAX_SLOTS - 1)) begin
                    n_count = '0;
                    if (r_clr_rsp) begin
                        n_status = lpht_pkg::ST_OK;
                        n_slot   = '0;
                        n_fv     = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_IDLE: begin
                if (req_acc) begin
                    n_op     = i_req.op;
                    n_key    = i_req.key;
                    n_val    = i_req.value;
                    n_reins  = 1'b0;
                    n_i      = '0;
                    n_status = lpht_pkg::ST_NOTFOUND;
                    n_slot   = '0;
                    n_fv     = '0;
                    if (i_req.op == lpht_pkg::OP_CLEAR) begin
                        n_clr_rsp = 1'b1;
                        n_sweep   = '0;
                        n_state   = S_CLR;
                    end else if (i_req.op > lpht_pkg::OP_NEXT) begin
                        n_state = S_DONE;
                    end else if (i_req.key == '0) begin
                        n_status = lpht_pkg::ST_ZEROKEY;
                        n_state  = S_DONE;
                    end else if (i_req.op == lpht_pkg::OP_NEXT) begin
                        n_mode  = M_NEXT;
                        n_s     = lpht_pkg::adv_slot(i_req.start_slot, n_active);
                        n_state = S_PRB;
                    end else begin
                        n_mode    = (i_req.op == lpht_pkg::OP_INSERT) ? M_PUT : M_FIND;
                        mod_start = 1'b1;
                        mod_key   = i_req.key;
                        n_state   = S_MOD;
                    end
                end
            end

            S_MOD: begin
                if (mod_done) begin
                    n_s     = mod_rem;
                    n_i     = '0;
                    n_state = S_PRB;
                end
            end

            S_PRB: begin
                n_state = S_CHK;
            end

            S_CHK: begin
                case (r_mode)
                    M_FIND: begin
                        if (is_empty) begin
                            n_state = S_DONE;
                        end else if (is_match) begin
                            n_status = lpht_pkg::ST_OK;
                            n_slot   = r_s;
                            n_fv     = r_val_rd;
                            if (r_op == lpht_pkg::OP_REMOVE) begin
                                key_we  = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - CW'(1);
                                end
                                n_scan  = lpht_pkg::adv_slot(r_s, n_active);
                                n_j     = '0;
                                n_state = S_SCAN_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end else if (exhausted) begin
                            n_state = S_DONE;
                        end else begin
                            n_s     = lpht_pkg::adv_slot(r_s, n_active);
                            n_i     = r_i + CW'(1);
                            n_state = S_PRB;
                        end
                    end

                    M_PUT: begin
                        if (is_empty || (is_match && !r_dup)) begin
                            val_we = 1'b1;
                            if (is_empty) begin
                                key_we    = 1'b1;
                                key_wdata = k_cur;
                                if (r_count < CW'(lpht_pkg::MAX_SLOTS)) begin
                                    n_count = r_count + CW'(1);
                                end
                            end
                            if (r_reins) begin
                                n_scan  = lpht_pkg::adv_slot(r_scan, n_active);
                                n_j     = r_j + CW'(1);
                                n_state = S_SCAN_RD;
                            end else begin
                                n_status = lpht_pkg::ST_OK;
                                n_slot   = r_s;
                                n_fv     = v_cur;
                                n_state  = S_DONE;
                            end
                        end else if (exhausted) begin
                            if (r_reins) begin
                                n_scan  = lpht_pkg::adv_slot(r_scan, n_active);
                                n_j     = r_j + CW'(1);
                                n_state = S_SCAN_RD;
                            end else begin
                                n_status = lpht_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end
                        end else begin
                            n_s     = lpht_pkg::adv_slot(r_s, n_active);
                            n_i     = r_i + CW'(1);
                            n_state = S_PRB;
                        end
                    end

                    M_NEXT: begin
                        if (is_empty) begin
                            n_state = S_DONE;
                        end else if (is_match) begin
                            n_status = lpht_pkg::ST_OK;
                            n_slot   = r_s;
                            n_fv     = r_val_rd;
                            n_state  = S_DONE;
                        end else if (exhausted) begin
                            n_state = S_DONE;
                        end else begin
                            n_s     = lpht_pkg::adv_slot(r_s, n_active);
                            n_i     = r_i + CW'(1);
                            n_state = S_PRB;
                        end
                    end

                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end

            // lift entry out, reinsert from home slot; empty slot stops
            S_SCAN_CHK: begin
                if ((r_j < n_active) && !is_empty) begin
                    n_mk      = r_key_rd;
                    n_mv      = r_val_rd;
                    key_we    = 1'b1;
                    key_waddr = r_scan;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                    n_mode    = M_PUT;
                    n_reins   = 1'b1;
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (rsp_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories: one write and one registered read each cycle
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        r_key_rd <= key_mem[raddr];
        r_val_rd <= val_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_count     <= '0;
            r_sweep     <= '0;
            r_clr_rsp   <= 1'b0;
            r_slots     <= CW'(lpht_pkg::MAX_SLOTS);
            r_dup       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sweep   <= n_sweep;
            r_clr_rsp <= n_clr_rsp;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lpht_pkg::CFG_SLOTS: r_slots <= i_cfg_data;
                    lpht_pkg::CFG_DUP:   r_dup   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_mode   <= n_mode;
        r_reins  <= n_reins;
        r_s      <= n_s;
        r_i      <= n_i;
        r_scan   <= n_scan;
        r_j      <= n_j;
        r_mk     <= n_mk;
        r_mv     <= n_mv;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_fv     <= n_fv;
        if (rsp_load) begin
            r_rsp.status      <= r_status;
            r_rsp.slot        <= r_slot;
            r_rsp.found_value <= r_fv;
            r_rsp.used_count  <= r_count;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(lpht_pkg::MAX_SLOTS))
        else $error("occupied count beyond table size");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!key_we && !val_we))
        else $error("memory write while idle");

    a_mod_start_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> ((r_state == S_IDLE) || (r_state == S_SCAN_CHK)))
        else $error("remainder started from wrong state");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_load |=> (r_rsp_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");

endmodule

@@ sim/tb_linear_probe_hash_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives random and directed table operations into the hash table, mirrors
// the table in a behavioral copy and checks every response field.
// ----------------------------------------------------------------------------

// Behavioral copy of the table; predicts each response and holds the queue
// of responses still to come.
class table_mirror;
    logic [lpht_pkg::KEY_BITS-1:0]   keys [lpht_pkg::MAX_SLOTS];
    logic [lpht_pkg::VALUE_BITS-1:0] vals [lpht_pkg::MAX_SLOTS];
    int unsigned                     used;
    logic [lpht_pkg::CNT_W-1:0]      slots_reg;
    bit                              dup_en;
    lpht_pkg::t_rsp                  pending [$];
    int                              errors;

    function new();
        for (int i = 0; i < lpht_pkg::MAX_SLOTS; i++) begin
            keys[i] = '0;
            vals[i] = '0;
        end
        used      = 0;
        slots_reg = lpht_pkg::CNT_W'(lpht_pkg::MAX_SLOTS);
        dup_en    = 0;
        errors    = 0;
    endfunction

    function int unsigned span();
        if (slots_reg == 0) return 1;
        if (slots_reg > lpht_pkg::MAX_SLOTS) return lpht_pkg::MAX_SLOTS;
        return 32'(slots_reg);
    endfunction

    function int unsigned step_slot(int unsigned s, int unsigned n);
        s++;
        return (s >= n) ? 0 : s;
    endfunction

    function int find_key(logic [lpht_pkg::KEY_BITS-1:0] k);
        int unsigned n, s;
        n = span();
        s = 32'(k % 64'(n));
        for (int i = 0; i < n; i++) begin
            if (keys[s] == 0) return -1;
            if (keys[s] == k) return int'(s);
            s = step_slot(s, n);
        end
        return -1;
    endfunction

    function int place(logic [lpht_pkg::KEY_BITS-1:0] k,
                       logic [lpht_pkg::VALUE_BITS-1:0] v);
        int unsigned n, s, i;
        n = span();
        s = 32'(k % 64'(n));
        for (i = 0; i < n; i++) begin
            if (keys[s] == 0) break;
            if (keys[s] == k && !dup_en) break;
            s = step_slot(s, n);
        end
        if (i >= n) return -1;
        if (keys[s] == 0) begin
            if (used < lpht_pkg::MAX_SLOTS) used++;
            keys[s] = k;
        end
        vals[s] = v;
        return int'(s);
    endfunction

    // note an accepted request and queue its response
    function void note_request(lpht_pkg::t_req r);
        lpht_pkg::t_rsp e;
        int   s;
        int unsigned n, p;
        logic [lpht_pkg::KEY_BITS-1:0]   mk;
        logic [lpht_pkg::VALUE_BITS-1:0] mv;
        n = span();
        e = '0;
        e.status = lpht_pkg::ST_NOTFOUND;
        if (r.op == lpht_pkg::OP_CLEAR) begin
            for (int i = 0; i < lpht_pkg::MAX_SLOTS; i++) keys[i] = '0;
            used = 0;
            e.status = lpht_pkg::ST_OK;
        end else if (r.op > lpht_pkg::OP_NEXT) begin
            e.status = lpht_pkg::ST_NOTFOUND;
        end else if (r.key == 0) begin
            e.status = lpht_pkg::ST_ZEROKEY;
        end else if (r.op == lpht_pkg::OP_LOOKUP) begin
            s = find_key(r.key);
            if (s >= 0) begin
                e.status = lpht_pkg::ST_OK;
                e.slot = lpht_pkg::SLOT_W'(s);
                e.found_value = vals[s];
            end
        end else if (r.op == lpht_pkg::OP_INSERT) begin
            s = place(r.key, r.value);
            if (s < 0) e.status = lpht_pkg::ST_FULL;
            else begin
                e.status = lpht_pkg::ST_OK;
                e.slot = lpht_pkg::SLOT_W'(s);
                e.found_value = vals[s];
            end
        end else if (r.op == lpht_pkg::OP_REMOVE) begin
            s = find_key(r.key);
            if (s >= 0) begin
                e.status = lpht_pkg::ST_OK;
                e.slot = lpht_pkg::SLOT_W'(s);
                e.found_value = vals[s];
                keys[s] = '0;
                if (used > 0) used--;
                // pull the rest of the cluster back in so probes still reach it
                p = step_slot(32'(s), n);
                for (int i = 0; i < n && keys[p] != 0; i++) begin
                    mk = keys[p];
                    mv = vals[p];
                    keys[p] = '0;
                    if (used > 0) used--;
                    void'(place(mk, mv));
                    p = step_slot(p, n);
                end
            end
        end else begin
            // next duplicate: starts one past start_slot
            p = 32'(r.start_slot);
            for (int i = 0; i < n; i++) begin
                p = step_slot(p, n);
                if (keys[p] == 0) break;
                if (keys[p] == r.key) begin
                    e.status = lpht_pkg::ST_OK;
                    e.slot = lpht_pkg::SLOT_W'(p);
                    e.found_value = vals[p];
                    break;
                end
            end
        end
        e.used_count = lpht_pkg::CNT_W'(used);
        pending.push_back(e);
    endfunction

    function void check_response(lpht_pkg::t_rsp a);
        lpht_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $error("response with none outstanding: %h", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
        end
        if (a.slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
        end
        if (a.found_value !== e.found_value) begin
            $error("found_value exp %h got %h", e.found_value, a.found_value);
            errors++;
        end
        if (a.used_count !== e.used_count) begin
            $error("used_count exp %0d got %0d", e.used_count, a.used_count);
            errors++;
        end
    endfunction
endclass

module tb_linear_probe_hash_table;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 64;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_req_valid;
    logic                          o_req_ready;
    lpht_pkg::t_req                i_req;
    logic                          o_rsp_valid;
    logic                          i_rsp_ready;
    lpht_pkg::t_rsp                o_rsp;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [lpht_pkg::CFG_W-1:0]    i_cfg_data;

    table_mirror mirror;
    int          cycles;
    bit          rx_hold;       // long receiver hold-off request
    bit          rx_holding;

    // key pool: small keys make clusters, collisions and duplicates likely
    logic [lpht_pkg::KEY_BITS-1:0] key_pool [16];

    linear_probe_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // request acceptance feeds the mirror
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready) mirror.note_request(i_req);
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial begin : receiver
        int w;
        i_rsp_ready = 1'b0;
        rx_holding  = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold) begin
                rx_holding = 1;
                i_rsp_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                rx_holding = 0;
                rx_hold = 0;
            end
            // at least a third of the time no stall at all
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (w > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            @(posedge i_clk iff o_rsp_valid);
            mirror.check_response(o_rsp);
        end
    end

    task automatic send_request(input lpht_pkg::t_req r, input int gap);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk iff o_req_ready);
    endtask

    task automatic idle_sender();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // step the clock before polling so the last accepted request is already noted
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // config write with no request in flight; mirror follows at the same edge
    task automatic write_config(input logic idx,
                                input logic [lpht_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == lpht_pkg::CFG_SLOTS) mirror.slots_reg = data;
        else mirror.dup_en = data[0];
        i_cfg_we <= 1'b0;
    endtask

    function automatic lpht_pkg::t_req make_req(logic [2:0] op,
                                                logic [lpht_pkg::KEY_BITS-1:0] k,
                                                logic [lpht_pkg::VALUE_BITS-1:0] v,
                                                logic [lpht_pkg::SLOT_W-1:0] st);
        lpht_pkg::t_req r;
        r.op = op; r.key = k; r.value = v; r.start_slot = st;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly real operations on pooled keys, some noise
    function automatic lpht_pkg::t_req random_req();
        int unsigned sel;
        logic [2:0]  op;
        logic [lpht_pkg::KEY_BITS-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 30)      op = lpht_pkg::OP_INSERT;
        else if (sel < 55) op = lpht_pkg::OP_LOOKUP;
        else if (sel < 75) op = lpht_pkg::OP_REMOVE;
        else if (sel < 93) op = lpht_pkg::OP_NEXT;
        else if (sel < 95) op = lpht_pkg::OP_CLEAR;
        else               op = 3'($urandom_range(5, 7));
        sel = $urandom_range(0, 99);
        if (sel < 80)      k = key_pool[$urandom_range(0, 15)];
        else if (sel < 83) k = '0;
        else               k = rand64();
        return make_req(op, k, rand64(), lpht_pkg::SLOT_W'($urandom()));
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_req(),
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    endtask

    task automatic refill_pool(input int unsigned spread);
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = lpht_pkg::KEY_BITS'($urandom_range(1, spread));
            if (i == 15) key_pool[i] = rand64() | 64'h8000_0000_0000_0000;
        end
    endtask

    initial begin : stimulus
        mirror      = new();
        cycles      = 0;
        rx_hold     = 0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= lpht_pkg::CFG_SLOTS;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tiny table, all ops, extremes and corner cases
        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(4));
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(0));
        send_request(make_req(lpht_pkg::OP_LOOKUP, '0, '1, '1), 0);        // zero key
        send_request(make_req(lpht_pkg::OP_INSERT, '0, '1, '0), 0);
        send_request(make_req(lpht_pkg::OP_REMOVE, '0, '0, '0), 0);
        send_request(make_req(lpht_pkg::OP_NEXT, '0, '0, '0), 0);
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd4, '1, '0), 0);
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd8, 64'h1, '0), 0);  // collides
        send_request(make_req(lpht_pkg::OP_INSERT, '1, '0, '0), 0);        // max key
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd4, 64'h55, '0), 0); // overwrite
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd12, 64'h2, '0), 0); // fills
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd5, 64'h3, '0), 0);  // full
        send_request(make_req(lpht_pkg::OP_LOOKUP, 64'd8, '0, '0), 0);
        send_request(make_req(lpht_pkg::OP_NEXT, 64'd8, '0, '1), 0);       // start wraps
        send_request(make_req(lpht_pkg::OP_NEXT, 64'd99, '0, 10'd2), 0);   // all probed
        send_request(make_req(lpht_pkg::OP_REMOVE, 64'd4, '0, '0), 0);     // cluster shift
        send_request(make_req(lpht_pkg::OP_REMOVE, 64'd4, '0, '0), 0);     // absent
        send_request(make_req(3'd5, 64'd1, '0, '0), 0);
        send_request(make_req(3'd7, 64'd1, '0, '0), 0);
        send_request(make_req(lpht_pkg::OP_CLEAR, '0, '0, '0), 0);
        wait_drained();
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(1));
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd3, 64'hA, '0), 0);
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd3, 64'hB, '0), 0);
        send_request(make_req(lpht_pkg::OP_NEXT, 64'd3, '0, 10'd3), 0);
        send_request(make_req(lpht_pkg::OP_LOOKUP, 64'd3, '0, '0), 0);
        wait_drained();
        write_config(lpht_pkg::CFG_SLOTS, '0);                             // acts as 1
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd7, 64'h7, '0), 0);
        send_request(make_req(lpht_pkg::OP_INSERT, 64'd9, 64'h9, '0), 0);
        wait_drained();

        // random phases over several table settings
        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(2047));        // clamps
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(0));
        refill_pool(5000);
        random_phase(250);
        wait_drained();

        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(16));
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(1));
        refill_pool(64);
        // long receiver hold-off while requests keep coming
        rx_hold = 1;
        random_phase(250);
        wait_drained();

        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(1));
        refill_pool(8);
        random_phase(150);
        wait_drained();

        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(37));
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(0));
        refill_pool(200);
        random_phase(400);
        wait_drained();

        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(8));
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(1));
        refill_pool(40);
        random_phase(350);
        wait_drained();

        write_config(lpht_pkg::CFG_SLOTS, lpht_pkg::CFG_W'(1024));
        write_config(lpht_pkg::CFG_DUP, lpht_pkg::CFG_W'(0));
        refill_pool(3000);
        random_phase(400);
        wait_drained();

        while (rx_holding) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
